// ===== sv/fit_policy_block_allocator_defines.svh =====
// Assertion macros for the fit-policy block allocator.
// Define NO_ASSERTIONS to leave every check out of the build.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset
`define FPBA_ASSERT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fpba assertion failed");

// Next-cycle implication, checked at every rising edge outside reset
`define FPBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fpba assertion failed");

`else

`define FPBA_ASSERT(lbl, clk, rst_n, ante, cons)
`define FPBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/fpba_pkg.sv =====
package fpba_pkg;

	// Field widths
	localparam int SIZE_W      = 16;
	localparam int BLK_IDX_W   = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int MAX_BLOCKS  = 5;
	localparam int DEF_BLOCK_COUNT = 5;

	// Action codes
	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// Policy codes
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	typedef struct packed {
		logic              action;
		logic [1:0]        policy;
		logic [SIZE_W-1:0] request_size;
		logic              last_of_batch;
	} req_t;

	typedef struct packed {
		logic                 granted;
		logic [BLK_IDX_W-1:0] block_index;
		logic [SIZE_W-1:0]    space_left;
		logic                 batch_done;
	} rsp_t;

	// Outcome of the block search for one request
	typedef struct packed {
		logic                 hit;
		logic [BLK_IDX_W-1:0] idx;
		logic [SIZE_W-1:0]    new_space;
	} pick_t;

endpackage

// ===== sv/fit_policy_block_allocator.sv =====
// Channel  Direction  Handshake               Beat
// req      in         req_valid / req_stall   fpba_pkg::req_t (action, policy, size, last)
// rsp      out        rsp_valid / rsp_stall   fpba_pkg::rsp_t (granted, block, space, done)
// cfg      in         cfg_we                  cfg_index selects capacity register, cfg_data
//
// One beat in, one beat out. A beat is held in the input register, then
// the block search and the add or subtract run in a single pass into the result
// register; one beat per cycle is sustained while rsp_stall is low.
// Reset clears capacities, remaining space and both valid flags.
// req_stall rises only while both registers are full and rsp_stall holds the result.
`include "fit_policy_block_allocator_defines.svh"

module fit_policy_block_allocator #(
	parameter int BLOCK_COUNT = fpba_pkg::DEF_BLOCK_COUNT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  fpba_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output fpba_pkg::rsp_t                   rsp,
	input  logic                             cfg_we,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fpba_pkg::SIZE_W-1:0]      cfg_data
);

	logic                        valid_s1;
	fpba_pkg::req_t              req_s1;
	logic                        valid_s2;
	fpba_pkg::rsp_t              rsp_s2;
	logic [fpba_pkg::SIZE_W-1:0] capacity_q  [BLOCK_COUNT];
	logic [fpba_pkg::SIZE_W-1:0] remaining_q [BLOCK_COUNT];
	fpba_pkg::pick_t             pick;
	logic                        advance;
	logic                        take;

	// Move the held beat on when the result register is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && valid_s2 && rsp_stall;
	assign take      = req_valid && !req_stall;

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	fpba_pick #(
		.BLOCK_COUNT(BLOCK_COUNT)
	) u_pick (
		.req       (req_s1),
		.remaining (remaining_q),
		.capacity  (capacity_q),
		.pick      (pick)
	);

	// Input register: control flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
	end

	// Result register: control flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register: payload; zero block and space on a failure
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2.granted     <= pick.hit;
			rsp_s2.block_index <= pick.hit ? pick.idx : '0;
			rsp_s2.space_left  <= pick.hit ? pick.new_space : '0;
			rsp_s2.batch_done  <= req_s1.last_of_batch;
		end
	end

	// Block state: a capacity write reloads the space, a grant updates it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BLOCK_COUNT; b++) begin
				capacity_q[b]  <= '0;
				remaining_q[b] <= '0;
			end
		end else begin
			for (int b = 0; b < BLOCK_COUNT; b++) begin
				if (cfg_we && cfg_index == fpba_pkg::CFG_IDX_W'(b)) begin
					capacity_q[b]  <= cfg_data;
					remaining_q[b] <= cfg_data;
				end else if (advance && pick.hit && pick.idx == fpba_pkg::BLK_IDX_W'(b)) begin
					remaining_q[b] <= pick.new_space;
				end
			end
		end
	end

	`FPBA_ASSERT(a_fail_zeroed, clk, arst_n, rsp_valid && !rsp.granted, rsp.block_index == '0 && rsp.space_left == '0)
	`FPBA_ASSERT(a_grant_in_range, clk, arst_n, rsp_valid && rsp.granted, rsp.block_index < fpba_pkg::BLK_IDX_W'(BLOCK_COUNT))
	`FPBA_ASSERT(a_stall_when_full, clk, arst_n, req_stall, valid_s1 && valid_s2)
	`FPBA_ASSERT_NEXT(a_advance_shows, clk, arst_n, advance, rsp_valid)

endmodule

// ===== sv/fpba_pick.sv =====
module fpba_pick #(
	parameter int BLOCK_COUNT = fpba_pkg::DEF_BLOCK_COUNT
) (
	input  fpba_pkg::req_t                    req,
	input  logic [fpba_pkg::SIZE_W-1:0]       remaining [BLOCK_COUNT],
	input  logic [fpba_pkg::SIZE_W-1:0]       capacity  [BLOCK_COUNT],
	output fpba_pkg::pick_t                   pick
);

	logic                                fits [BLOCK_COUNT];
	logic                                frees [BLOCK_COUNT];
	logic                                found;
	logic [fpba_pkg::BLK_IDX_W-1:0]      sel;
	logic [fpba_pkg::SIZE_W-1:0]         sel_rem;
	logic [fpba_pkg::SIZE_W-1:0]         used;

	// Per-block tests: room for an allocation, enough in use for a release
	always_comb begin
		used = '0;
		for (int b = 0; b < BLOCK_COUNT; b++) begin
			fits[b] = remaining[b] >= req.request_size;
			used = (capacity[b] >= remaining[b]) ? capacity[b] - remaining[b] : '0;
			frees[b] = used >= req.request_size;
		end
	end

	// Walk the blocks in index order; ties under best and worst fit go to the later block
	always_comb begin
		found   = 1'b0;
		sel     = '0;
		sel_rem = '0;
		for (int b = 0; b < BLOCK_COUNT; b++) begin
			if (req.action == fpba_pkg::ACT_RELEASE) begin
				if (!found && frees[b]) begin
					found   = 1'b1;
					sel     = fpba_pkg::BLK_IDX_W'(b);
					sel_rem = remaining[b];
				end
			end else begin
				case (req.policy)
					fpba_pkg::POL_FIRST: begin
						if (!found && fits[b]) begin
							found   = 1'b1;
							sel     = fpba_pkg::BLK_IDX_W'(b);
							sel_rem = remaining[b];
						end
					end
					fpba_pkg::POL_BEST: begin
						if (fits[b] && (!found || remaining[b] <= sel_rem)) begin
							found   = 1'b1;
							sel     = fpba_pkg::BLK_IDX_W'(b);
							sel_rem = remaining[b];
						end
					end
					fpba_pkg::POL_WORST: begin
						if (fits[b] && (!found || remaining[b] >= sel_rem)) begin
							found   = 1'b1;
							sel     = fpba_pkg::BLK_IDX_W'(b);
							sel_rem = remaining[b];
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Grant needs a non-zero size; adjust the chosen block's space
	always_comb begin
		pick.hit = found && (req.request_size != '0);
		pick.idx = sel;
		if (req.action == fpba_pkg::ACT_RELEASE) begin
			pick.new_space = sel_rem + req.request_size;
		end else begin
			pick.new_space = sel_rem - req.request_size;
		end
	end

endmodule
